// ===== sv/hashed_backend_selector_assert.svh =====
// ----------------------------------------------------------------------------
// hashed_backend_selector_assert.svh
// Assertion macros shared by the checker of the backend selector.
// ----------------------------------------------------------------------------
`ifndef HASHED_BACKEND_SELECTOR_ASSERT_SVH
`define HASHED_BACKEND_SELECTOR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define HBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hashed_backend_selector check failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define HBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hashed_backend_selector check failed");

`endif

// ===== sv/hbs_pkg.sv =====
// ----------------------------------------------------------------------------
// hbs_pkg
// Types, constants and hash helpers of the hashed backend selector.
// ----------------------------------------------------------------------------
package hbs_pkg;

  // Table geometry
  localparam int unsigned IndexBits  = 13;
  localparam int unsigned TableDepth = 1 << IndexBits;

  // Item actions
  localparam logic ActWrite  = 1'b0;
  localparam logic ActSelect = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] RegSticky    = 2'd0;
  localparam logic [1:0] RegLeastConn = 2'd1;
  localparam logic [1:0] RegWeight    = 2'd2;
  localparam logic [1:0] RegDefcon    = 2'd3;

  // Defcon handling
  localparam logic [2:0] DefconDefault = 3'd5;
  localparam logic [2:0] DefconSave    = 3'd4;

  typedef struct packed {
    logic        action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_tcp;
    logic [12:0] entry_index;
    logic [7:0]  entry_value;
  } hbs_in_t;

  typedef struct packed {
    logic [7:0] backend;
    logic       found;
    logic       by_least_conns;
  } hbs_out_t;

  typedef struct packed {
    logic       sticky;
    logic [7:0] least_conns_backend;
    logic [7:0] weight;
    logic [2:0] defcon_level;
  } hbs_cfg_t;

  // Table access issued by the hash pipeline
  typedef struct packed {
    logic                 valid;
    logic                 select;
    logic [IndexBits-1:0] addr;
    logic [7:0]           value;
    logic                 over;
  } hbs_lookup_t;

  // One sdbm step on 16 bits: h*65599 + c reduces to h*63 + c
  function automatic logic [15:0] hash_byte(logic [15:0] h, logic [7:0] c);
    logic [15:0] sh;
    sh = {h[9:0], 6'b0};
    return sh - h + {8'h00, c};
  endfunction

  // Four bytes, most significant first
  function automatic logic [15:0] hash_word(logic [15:0] h, logic [31:0] v);
    logic [15:0] acc;
    acc = h;
    for (int i = 3; i >= 0; i--) begin
      acc = hash_byte(acc, v[8*i +: 8]);
    end
    return acc;
  endfunction

  // 0 and out-of-range levels count as the default
  function automatic logic [2:0] effective_defcon(logic [2:0] d);
    if ((d == 3'd0) || (d > DefconDefault)) begin
      return DefconDefault;
    end
    return d;
  endfunction

endpackage

// ===== sv/hashed_backend_selector.sv =====
// ----------------------------------------------------------------------------
// hashed_backend_selector
// Stages: a select passes hash stages A and B, the table read stage and the
// output register before its result strobe rises.
// Throughput: one transaction per cycle; busy stays low, the strobe cannot
// be stalled. Writes go to the table in order with selects, so no hazards.
// Reset clears the pipeline valids and the configuration registers; table contents are
// undefined until written, there is no clearing pass.
// ----------------------------------------------------------------------------
module hashed_backend_selector (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hbs_pkg::hbs_in_t  item_i,
  output logic              result_valid_o,
  output hbs_pkg::hbs_out_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import hbs_pkg::*;

  hbs_cfg_t    cfg_q;
  hbs_lookup_t lookup;
  logic        accept, cfg_wr;
  logic [7:0]  rdata;
  logic        c_valid_q, c_over_q;
  logic        res_valid_q;
  hbs_out_t    res_q, res_d;

  // Never back-pressures
  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegSticky:    cfg_q.sticky              <= pwdata[0];
        RegLeastConn: cfg_q.least_conns_backend <= pwdata[7:0];
        RegWeight:    cfg_q.weight              <= pwdata[7:0];
        RegDefcon:    cfg_q.defcon_level        <= pwdata[2:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      RegSticky:    prdata = {31'h0, cfg_q.sticky};
      RegLeastConn: prdata = {24'h0, cfg_q.least_conns_backend};
      RegWeight:    prdata = {24'h0, cfg_q.weight};
      RegDefcon:    prdata = {29'h0, cfg_q.defcon_level};
      default:      prdata = 32'h0;
    endcase
  end

  // Hash pipeline
  hbs_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item_i),
    .cfg_i    (cfg_q),
    .lookup_o (lookup)
  );

  // Backend table
  hbs_ram #(
    .Width (8),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (lookup.valid && !lookup.select),
    .waddr_i (lookup.addr),
    .wdata_i (lookup.value),
    .re_i    (lookup.valid && lookup.select),
    .raddr_i (lookup.addr),
    .rdata_o (rdata)
  );

  // Read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else begin
      c_valid_q <= lookup.valid && lookup.select;
    end
  end

  always_ff @(posedge clk_i) begin
    c_over_q <= lookup.over;
  end

  // Final choice
  always_comb begin
    res_d.by_least_conns = c_over_q;
    res_d.backend        = c_over_q ? cfg_q.least_conns_backend : rdata;
    res_d.found          = (res_d.backend != 8'h00);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== sv/hbs_ram.sv =====
// ----------------------------------------------------------------------------
// hbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hbs_hash.sv =====
// ----------------------------------------------------------------------------
// hbs_hash
// Three-stage sdbm pipeline over the twelve tuple bytes; issues the table
// access (write entry or read slot) in item order from its last stage.
// ----------------------------------------------------------------------------
module hbs_hash (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hbs_pkg::hbs_in_t    item_i,
  input  hbs_pkg::hbs_cfg_t   cfg_i,
  output hbs_pkg::hbs_lookup_t lookup_o
);
  import hbs_pkg::*;

  logic        a_valid_q, b_valid_q;
  hbs_in_t     a_item_q, b_item_q;
  logic [15:0] a_hash_q, b_hash_q;
  logic [15:0] a_hash_d, b_hash_d, c_hash;
  logic [31:0] ports;
  logic        over;

  // Stage A: source address bytes
  assign a_hash_d = hash_word(16'h0000, item_i.src_addr);
  // Stage B: destination address bytes
  assign b_hash_d = hash_word(a_hash_q, a_item_q.dst_addr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_item_q <= item_i;
    a_hash_q <= a_hash_d;
    b_item_q <= a_item_q;
    b_hash_q <= b_hash_d;
  end

  // Stage C: port bytes, zeroed in sticky mode
  assign ports  = cfg_i.sticky ? 32'h0 : {b_item_q.src_port, b_item_q.dst_port};
  assign c_hash = hash_word(b_hash_q, ports);

  // Least-connections override decision
  assign over = b_item_q.is_tcp
             && (cfg_i.least_conns_backend != 8'h00)
             && (c_hash[7:0] < cfg_i.weight)
             && (effective_defcon(cfg_i.defcon_level) >= DefconSave);

  // Table access for this transaction
  always_comb begin
    lookup_o.valid  = b_valid_q;
    lookup_o.select = (b_item_q.action == ActSelect);
    lookup_o.value  = b_item_q.entry_value;
    lookup_o.over   = over;
    if (b_item_q.action == ActSelect) begin
      lookup_o.addr = c_hash[IndexBits-1:0];
    end else begin
      lookup_o.addr = IndexBits'(b_item_q.entry_index);
    end
  end

endmodule

// ===== sv/hbs_checker.sv =====
// ----------------------------------------------------------------------------
// hbs_port_checks
// Port-level checks on the backend selector, bound to the top level.
// ----------------------------------------------------------------------------
`include "hashed_backend_selector_assert.svh"

module hbs_port_checks (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input hbs_pkg::hbs_in_t  item_i,
  input logic              result_valid_o,
  input hbs_pkg::hbs_out_t result_o,
  input logic              pready
);
  import hbs_pkg::*;

  // Each result traces back to an accepted select
  `HBS_ASSERT_IMPL(a_result_origin, result_valid_o,
                   $past(start && !busy && (item_i.action == ActSelect), 4))

  // found follows the backend number
  `HBS_ASSERT_IMPL(a_found, result_valid_o, result_o.found == (result_o.backend != 8'h00))

  // Override only ever picks a real backend
  `HBS_ASSERT_IMPL(a_override_found, result_valid_o && result_o.by_least_conns,
                   result_o.found)

  // An accepted select always yields a result
  `HBS_ASSERT_NEXT(a_select_result, start && !busy && (item_i.action == ActSelect),
                   ##3 result_valid_o)

  // Port never back-pressures
  `HBS_ASSERT_IMPL(a_ready, 1'b1, pready && !busy)

endmodule

bind hashed_backend_selector hbs_port_checks u_hbs_port_checks (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .item_i         (item_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .pready         (pready)
);
